@@ hdl/ihex_pkg.sv @@
package ihex_pkg;

   localparam int unsigned PosWidth = 10;

   typedef logic [PosWidth-1:0] pos_type;
   typedef logic [1:0]          mode_type;

   // line modes
   localparam mode_type ModeStart  = 2'd0;
   localparam mode_type ModeRecord = 2'd1;
   localparam mode_type ModeSkip   = 2'd2;

   // characters
   localparam logic [7:0] ColonChar   = 8'h3A;
   localparam logic [7:0] NewlineChar = 8'd10;

   // record types
   localparam logic [7:0] RecData   = 8'h00;
   localparam logic [7:0] RecEof    = 8'h01;
   localparam logic [7:0] RecExtLin = 8'h04;

   // result kinds
   localparam logic KindData = 1'b0;
   localparam logic KindEnd  = 1'b1;

   // digit positions within a record line (colon is position 0)
   localparam pos_type PosLenFirst  = 10'd1;
   localparam pos_type PosLenLast   = 10'd2;
   localparam pos_type PosOffFirst  = 10'd3;
   localparam pos_type PosOffLast   = 10'd6;
   localparam pos_type PosTypeFirst = 10'd7;
   localparam pos_type PosTypeLast  = 10'd8;
   localparam pos_type PosDataFirst = 10'd9;
   localparam pos_type PosExt2      = 10'd10;
   localparam pos_type PosExt3      = 10'd11;
   localparam pos_type PosExtLast   = 10'd12;
   localparam pos_type PosMax       = 10'd1023;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [31:0] byte_address;
      logic [7:0]  data_byte;
   } result_type;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] n;
      n = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         n = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         n = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         n = 4'(c - 8'h57);
      end
      return n;
   endfunction

endpackage

@@ hdl/ihex_parse.sv @@
module ihex_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                beat_accept,
   input  logic [7:0]          text_char,
   output ihex_pkg::result_type res
);

   ihex_pkg::mode_type mode_ff, mode_in;
   ihex_pkg::pos_type  pos_ff, pos_in;
   logic [3:0]  high_ff, high_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] offset_ff, offset_in;
   logic [7:0]  kind_ff, kind_in;
   logic [15:0] upper_ff, upper_in;
   logic        finished_ff, finished_in;

   logic [3:0]          nib;
   ihex_pkg::pos_type   data_idx;

   assign nib      = ihex_pkg::nibble_of(text_char);
   assign data_idx = pos_ff - ihex_pkg::PosDataFirst;

   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_ff;
      high_in     = high_ff;
      len_in      = len_ff;
      offset_in   = offset_ff;
      kind_in     = kind_ff;
      upper_in    = upper_ff;
      finished_in = finished_ff;
      res         = '0;

      if (beat_accept && !finished_ff) begin
         if (text_char == ihex_pkg::NewlineChar) begin
            // short extended-address line: align the digits that did arrive
            if (mode_ff == ihex_pkg::ModeRecord && kind_ff == ihex_pkg::RecExtLin) begin
               case (pos_ff)
                  ihex_pkg::PosDataFirst: upper_in = 16'h0;
                  ihex_pkg::PosExt2:      upper_in = {upper_ff[3:0], 12'h0};
                  ihex_pkg::PosExt3:      upper_in = {upper_ff[7:0], 8'h0};
                  ihex_pkg::PosExtLast:   upper_in = {upper_ff[11:0], 4'h0};
                  default:                upper_in = upper_ff;
               endcase
            end
            mode_in = ihex_pkg::ModeStart;
            pos_in  = '0;
         end else if (mode_ff == ihex_pkg::ModeStart) begin
            if (text_char == ihex_pkg::ColonChar) begin
               mode_in   = ihex_pkg::ModeRecord;
               pos_in    = ihex_pkg::PosLenFirst;
               len_in    = '0;
               offset_in = '0;
               kind_in   = '0;
               high_in   = '0;
            end else begin
               mode_in = ihex_pkg::ModeSkip;
            end
         end else if (mode_ff == ihex_pkg::ModeRecord) begin
            if (pos_ff != ihex_pkg::PosMax) begin
               pos_in = pos_ff + 10'd1;
            end
            if (pos_ff inside {[ihex_pkg::PosLenFirst:ihex_pkg::PosLenLast]}) begin
               len_in = {len_ff[3:0], nib};
            end else if (pos_ff inside {[ihex_pkg::PosOffFirst:ihex_pkg::PosOffLast]}) begin
               offset_in = {offset_ff[11:0], nib};
            end else if (pos_ff inside {[ihex_pkg::PosTypeFirst:ihex_pkg::PosTypeLast]}) begin
               kind_in = {kind_ff[3:0], nib};
               if (pos_ff == ihex_pkg::PosTypeLast && kind_in == ihex_pkg::RecEof) begin
                  finished_in = 1'b1;
                  res.valid   = 1'b1;
                  res.kind    = ihex_pkg::KindEnd;
               end
            end else if (pos_ff >= ihex_pkg::PosDataFirst) begin
               if (kind_ff == ihex_pkg::RecData) begin
                  if (data_idx < {1'b0, len_ff, 1'b0}) begin
                     if (!data_idx[0]) begin
                        high_in = nib;
                     end else begin
                        // data_idx stays below 510 here, so bits 8:1 hold the byte index
                        res.valid        = 1'b1;
                        res.kind         = ihex_pkg::KindData;
                        res.byte_address = {upper_ff, 16'h0} + {16'h0, offset_ff}
                                         + {24'h0, data_idx[8:1]};
                        res.data_byte    = {high_ff, nib};
                     end
                  end
               end else if (kind_ff == ihex_pkg::RecExtLin
                            && pos_ff <= ihex_pkg::PosExtLast) begin
                  if (pos_ff == ihex_pkg::PosDataFirst) begin
                     upper_in = {12'h0, nib};
                  end else begin
                     upper_in = {upper_ff[11:0], nib};
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= ihex_pkg::ModeStart;
         pos_ff      <= '0;
         high_ff     <= '0;
         len_ff      <= '0;
         offset_ff   <= '0;
         kind_ff     <= '0;
         upper_ff    <= '0;
         finished_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         pos_ff      <= pos_in;
         high_ff     <= high_in;
         len_ff      <= len_in;
         offset_ff   <= offset_in;
         kind_ff     <= kind_in;
         upper_ff    <= upper_in;
         finished_ff <= finished_in;
      end
   end

endmodule

@@ hdl/ihex_out_reg.sv @@
module ihex_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ihex_pkg::result_type res,
   output logic                 free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_kind,
   output logic [31:0]          rsp_byte_address,
   output logic [7:0]           rsp_data_byte
);

   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [7:0]  data_ff, data_in;

   // register can take a new beat when empty or draining this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = res.valid;
         kind_in  = res.kind;
         addr_in  = res.byte_address;
         data_in  = res.data_byte;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_byte_address = addr_ff;
   assign rsp_data_byte    = data_ff;

endmodule

@@ hdl/intel_hex_record_parser.sv @@
// Intel HEX record parser.
// Input channel (req_valid/req_ready/req_text_char): one text character per
// beat; newline ends a line, lines not starting with a colon are skipped.
// Result channel (rsp_valid/rsp_ready/rsp_*): one beat per decoded data byte
// with its full 32-bit address (kind 0), or one end marker (kind 1) when the
// end-of-file record type is seen; after that all input is taken and dropped.
// A result is registered and appears on rsp_* in the cycle after the
// character that completes it is accepted.
// Throughput: one character per cycle while the output register is free.
// The parser state updates in the cycle a character is accepted; the single
// output register decides readiness. req_ready is high whenever the output
// register is empty or being drained, so a stalled receiver holds at most
// one pending result and stops input until that beat is taken.
// Reset clears the line state, the extended address and the end flag; the
// output register comes up empty.
module intel_hex_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_text_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [31:0] rsp_byte_address,
   output logic [7:0]  rsp_data_byte
);

   ihex_pkg::result_type res;
   logic                 free;
   logic                 beat_accept;

   assign req_ready   = free;
   assign beat_accept = req_valid && free;

   ihex_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .beat_accept (beat_accept),
      .text_char   (req_text_char),
      .res         (res)
   );

   ihex_out_reg u_out_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (beat_accept),
      .res              (res),
      .free             (free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_byte_address (rsp_byte_address),
      .rsp_data_byte    (rsp_data_byte)
   );

endmodule
